// ===== src/bsbie_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap set-bit index extraction package
// Shared widths, constants, state encoding and inter-module types.
// ----------------------------------------------------------------------------
package bsbie_pkg;

  // Fixed geometry of one bitmap word and the batch it belongs to.
  localparam int unsigned WordBits      = 64;
  localparam int unsigned PosWidth      = $clog2(WordBits);
  localparam int unsigned WordIdxWidth  = 5;
  localparam int unsigned RowIdxWidth   = WordIdxWidth + PosWidth;
  localparam int unsigned RowCountWidth = 12;
  localparam int unsigned BatchRows     = 2048;
  localparam int unsigned UsedWidth     = RowCountWidth - PosWidth + 1;

  localparam logic [RowCountWidth-1:0] RowCountReset = RowCountWidth'(BatchRows);

  // Packed stream widths, rounded up to whole bytes.
  localparam int unsigned InDataWidth  = ((WordBits + WordIdxWidth + 7) / 8) * 8;
  localparam int unsigned OutDataWidth = ((RowIdxWidth + 7) / 8) * 8;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } scan_state_e;

  // One result handed from the scanner to the output register.
  typedef struct packed {
    logic                   valid;
    logic [RowIdxWidth-1:0] row_index;
    logic                   last;
  } result_t;

endpackage

// ===== src/bitmap_set_bit_index_extract_unit.sv =====
// ----------------------------------------------------------------------------
// Bitmap set-bit index extraction unit
// Turns one 64-bit selection word into the ascending list of selected rows.
// ----------------------------------------------------------------------------
// A result passes through the scanner's shift register and then the output
// register; the scanner first shifts past every lower bit position.
// The scanner takes a new word only once it has finished the previous one,
// shifting one bit position at a time; output stalls hold the scan.
// Words that are empty after trimming leave the scanner idle and ready.
// Reset clears all control state and sets the row count to 2048.
// ----------------------------------------------------------------------------
module bitmap_set_bit_index_extract_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Row count register write port.
  input  logic                                  cfg_we_i,
  input  logic [bsbie_pkg::RowCountWidth-1:0]   cfg_wdata_i,
  // Input stream.
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [63:0] mask_word, [68:64] word_index, [71:69] zero
  input  logic [bsbie_pkg::InDataWidth-1:0]     s_axis_tdata,
  // Output stream.
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [10:0] row_index, [15:11] zero
  output logic [bsbie_pkg::OutDataWidth-1:0]    m_axis_tdata,
  // last_of_word
  output logic                                  m_axis_tlast
);

  logic [bsbie_pkg::RowCountWidth-1:0] row_count_q;

  logic [bsbie_pkg::WordBits-1:0]      mask_word;
  logic [bsbie_pkg::WordIdxWidth-1:0]  word_index;
  logic [bsbie_pkg::RowCountWidth-1:0] eff_rows;
  logic [bsbie_pkg::UsedWidth-1:0]     live_words;
  logic [bsbie_pkg::PosWidth-1:0]      rem_bits;
  logic [bsbie_pkg::UsedWidth-1:0]     word_ext;
  logic [bsbie_pkg::WordBits-1:0]      tail_mask;
  logic [bsbie_pkg::WordBits-1:0]      trimmed;

  logic               start;
  logic               scan_ready;
  logic               out_free;
  bsbie_pkg::result_t result;

  // The row count register; the user must write it only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= bsbie_pkg::RowCountReset;
    end else if (cfg_we_i) begin
      row_count_q <= cfg_wdata_i;
    end
  end

  assign mask_word  = s_axis_tdata[bsbie_pkg::WordBits-1:0];
  assign word_index = s_axis_tdata[bsbie_pkg::WordBits +: bsbie_pkg::WordIdxWidth];

  // Row counts above the batch size behave as a full batch.
  assign eff_rows = (row_count_q > bsbie_pkg::RowCountReset) ?
                    bsbie_pkg::RowCountReset : row_count_q;

  // Number of words that hold valid rows, and the valid bits of the last one.
  assign live_words = bsbie_pkg::UsedWidth'(
                        ({1'b0, eff_rows} + (bsbie_pkg::RowCountWidth + 1)'(
                          bsbie_pkg::WordBits - 1)) >> bsbie_pkg::PosWidth);
  assign rem_bits   = eff_rows[bsbie_pkg::PosWidth-1:0];
  assign word_ext   = bsbie_pkg::UsedWidth'(word_index);
  assign tail_mask  = ({{(bsbie_pkg::WordBits-1){1'b0}}, 1'b1} << rem_bits) -
                      {{(bsbie_pkg::WordBits-1){1'b0}}, 1'b1};

  // Words past the used range emit nothing; the last partial word loses the
  // bits at or above the row count.
  always_comb begin
    trimmed = mask_word;
    if (word_ext >= live_words) begin
      trimmed = '0;
    end else if ((rem_bits != '0) && (word_ext == live_words - 1'b1)) begin
      trimmed = mask_word & tail_mask;
    end
  end

  assign s_axis_tready = scan_ready;
  assign start         = s_axis_tvalid && scan_ready;

  bsbie_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .bits_i     (trimmed),
    .word_i     (word_index),
    .out_free_i (out_free),
    .ready_o    (scan_ready),
    .result_o   (result)
  );

  // A register slot decouples the scanner from downstream stalls.
  bsbie_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .result_i      (result),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== src/bsbie_scan.sv =====
// ----------------------------------------------------------------------------
// Bitmap set-bit scanner
// Shifts a loaded word right one position per cycle and emits the row index
// of every set bit it passes, stalling on a set bit while the output slot is full.
// ----------------------------------------------------------------------------
module bsbie_scan (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [bsbie_pkg::WordBits-1:0]       bits_i,
  input  logic [bsbie_pkg::WordIdxWidth-1:0]   word_i,
  input  logic                                 out_free_i,
  output logic                                 ready_o,
  output bsbie_pkg::result_t                   result_o
);

  bsbie_pkg::scan_state_e state_q, state_d;

  logic [bsbie_pkg::WordBits-1:0]     bits_q, bits_d;
  logic [bsbie_pkg::PosWidth-1:0]     pos_q, pos_d;
  logic [bsbie_pkg::WordIdxWidth-1:0] word_q, word_d;

  logic rest_zero;
  logic advance;
  logic load;

  // All bits above the current position are clear: this set bit is the last.
  assign rest_zero = (bits_q[bsbie_pkg::WordBits-1:1] == '0);
  assign load      = start_i && (state_q == bsbie_pkg::ST_IDLE);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      bsbie_pkg::ST_IDLE: begin
        if (start_i && (bits_i != '0)) begin
          state_d = bsbie_pkg::ST_SCAN;
        end
      end
      bsbie_pkg::ST_SCAN: begin
        if (bits_q[0] && out_free_i && rest_zero) begin
          state_d = bsbie_pkg::ST_IDLE;
        end
      end
      default: state_d = bsbie_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    ready_o            = 1'b0;
    advance            = 1'b0;
    result_o.valid     = 1'b0;
    result_o.row_index = {word_q, pos_q};
    result_o.last      = rest_zero;
    case (state_q)
      bsbie_pkg::ST_IDLE: begin
        ready_o = 1'b1;
      end
      bsbie_pkg::ST_SCAN: begin
        advance        = !bits_q[0] || out_free_i;
        result_o.valid = bits_q[0] && out_free_i;
      end
      default: ready_o = 1'b0;
    endcase
  end

  // Shift datapath.
  always_comb begin
    bits_d = bits_q;
    pos_d  = pos_q;
    word_d = word_q;
    if (load) begin
      bits_d = bits_i;
      pos_d  = '0;
      word_d = word_i;
    end else if (advance) begin
      bits_d = bits_q >> 1;
      pos_d  = pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bsbie_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q <= bits_d;
    pos_q  <= pos_d;
    word_q <= word_d;
  end

endmodule

// ===== src/bsbie_out.sv =====
// ----------------------------------------------------------------------------
// Bitmap set-bit output register
// Holds one result transaction until the downstream side takes it.
// ----------------------------------------------------------------------------
module bsbie_out (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  bsbie_pkg::result_t                   result_i,
  output logic                                 free_o,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [bsbie_pkg::OutDataWidth-1:0]   m_axis_tdata,
  output logic                                 m_axis_tlast
);

  logic                                valid_q, valid_d;
  logic [bsbie_pkg::RowIdxWidth-1:0]   row_q, row_d;
  logic                                last_q, last_d;

  // The slot can take a new result when empty or when being drained now.
  assign free_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    row_d   = row_q;
    last_d  = last_q;
    if (free_o) begin
      valid_d = result_i.valid;
    end
    if (result_i.valid) begin
      row_d  = result_i.row_index;
      last_d = result_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q  <= row_d;
    last_q <= last_d;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = bsbie_pkg::OutDataWidth'(row_q);
  assign m_axis_tlast  = last_q;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the bitmap set-bit index extraction unit
// Streams 64-bit selection words in and checks every emitted row index and
// end-of-word flag against a predictor kept in step with the row count
// register. A short directed table covers the corner cases, then random
// words run under three idle patterns and many row count settings.
// ----------------------------------------------------------------------------
module tb;

  // Cycles with no transaction on either stream before the run is given up.
  // The slowest legitimate quiet stretch is the settle time before a
  // register write plus one full word scan, far below this.
  localparam int unsigned StallLimit = 4000;
  // Cycles allowed for a word that emits nothing to leave the scanner.
  localparam int unsigned SettleCycles = 80;

  localparam logic [bsbie_pkg::WordBits-1:0] AllOnes = '1;
  localparam logic [bsbie_pkg::WordBits-1:0] TopBit  = 64'h8000_0000_0000_0000;

  // One expected output transaction.
  typedef struct packed {
    logic [bsbie_pkg::RowIdxWidth-1:0] row;
    logic                              last;
  } selected_row_t;

  // One directed word. When typed is set, hit and idx give the result typed
  // in by hand (at most one row); otherwise the predictor decides.
  typedef struct packed {
    logic [bsbie_pkg::RowCountWidth-1:0] rc;
    logic [bsbie_pkg::WordBits-1:0]      mask;
    logic [bsbie_pkg::WordIdxWidth-1:0]  widx;
    logic                                typed;
    logic                                hit;
    logic [bsbie_pkg::RowIdxWidth-1:0]   idx;
  } directed_word_t;

  localparam directed_word_t Plan [22] = '{
    // Reset row count: lowest and highest row of the batch, an empty word, full and alternating words.
    '{12'd2048, 64'h1,   5'd0,  1'b1, 1'b1, 11'd0},
    '{12'd2048, TopBit,  5'd31, 1'b1, 1'b1, 11'd2047},
    '{12'd2048, 64'h0,   5'd5,  1'b1, 1'b0, 11'd0},
    '{12'd2048, AllOnes, 5'd0,  1'b0, 1'b0, 11'd0},
    '{12'd2048, AllOnes, 5'd31, 1'b0, 1'b0, 11'd0},
    '{12'd2048, 64'hAAAA_AAAA_AAAA_AAAA, 5'd17, 1'b0, 1'b0, 11'd0},
    // Row count zero: nothing is ever selected.
    '{12'd0,    AllOnes, 5'd0,  1'b1, 1'b0, 11'd0},
    '{12'd0,    AllOnes, 5'd31, 1'b1, 1'b0, 11'd0},
    // One row: only bit 0 of word 0 survives trimming.
    '{12'd1,    AllOnes, 5'd0,  1'b1, 1'b1, 11'd0},
    '{12'd1,    64'hFFFF_FFFF_FFFF_FFFE, 5'd0, 1'b1, 1'b0, 11'd0},
    '{12'd1,    AllOnes, 5'd1,  1'b1, 1'b0, 11'd0},
    // Exactly one full word, then one row into the second word.
    '{12'd64,   AllOnes, 5'd0,  1'b0, 1'b0, 11'd0},
    '{12'd64,   AllOnes, 5'd1,  1'b1, 1'b0, 11'd0},
    '{12'd65,   AllOnes, 5'd1,  1'b1, 1'b1, 11'd64},
    '{12'd100,  64'h5555_5555_5555_5555, 5'd1, 1'b0, 1'b0, 11'd0},
    // One row short of the batch: the top bit of the last word is cleared.
    '{12'd2047, AllOnes, 5'd31, 1'b0, 1'b0, 11'd0},
    '{12'd2047, TopBit,  5'd31, 1'b1, 1'b0, 11'd0},
    // Counts above the batch size saturate to the full batch.
    '{12'd4095, TopBit,  5'd31, 1'b1, 1'b1, 11'd2047},
    '{12'd4095, 64'h8000_0001_0000_0010, 5'd7, 1'b0, 1'b0, 11'd0},
    '{12'd2049, AllOnes, 5'd31, 1'b0, 1'b0, 11'd0},
    // Trim boundary inside a second word: bit 62 kept, bit 63 dropped.
    '{12'd127,  64'h4000_0000_0000_0000, 5'd1, 1'b1, 1'b1, 11'd126},
    '{12'd127,  TopBit,  5'd1,  1'b1, 1'b0, 11'd0}
  };

  logic                                clk_i         = 1'b0;
  logic                                rst_ni        = 1'b0;
  logic                                cfg_we_i      = 1'b0;
  logic [bsbie_pkg::RowCountWidth-1:0] cfg_wdata_i   = '0;
  logic                                s_axis_tvalid = 1'b0;
  logic                                s_axis_tready;
  logic [bsbie_pkg::InDataWidth-1:0]   s_axis_tdata  = '0;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready = 1'b0;
  logic [bsbie_pkg::OutDataWidth-1:0]  m_axis_tdata;
  logic                                m_axis_tlast;

  // Predictor copy of the row count register, updated with every write.
  logic [bsbie_pkg::RowCountWidth-1:0] row_count_q = bsbie_pkg::RowCountReset;
  // Row indices predicted but not yet seen on the output stream.
  selected_row_t            pending_rows [$];
  int unsigned              mismatch_count = 0;
  int unsigned              quiet_cycles   = 0;
  // Idle percentages of the word sender and the row receiver.
  int unsigned              tx_idle_pct = 0;
  int unsigned              rx_idle_pct = 0;

  bitmap_set_bit_index_extract_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Number of bitmap words that hold valid rows under the current count.
  function automatic int unsigned live_word_count();
    int unsigned rows;
    rows = (row_count_q > bsbie_pkg::BatchRows) ? bsbie_pkg::BatchRows : row_count_q;
    return (rows + bsbie_pkg::WordBits - 1) / bsbie_pkg::WordBits;
  endfunction

  // Appends one expected row transaction to the tail of the queue.
  function automatic void expect_row(input logic [bsbie_pkg::RowIdxWidth-1:0] row,
                                     input logic last);
    selected_row_t entry;
    entry.row  = row;
    entry.last = last;
    pending_rows.insert(pending_rows.size(), entry);
  endfunction

  // Queues the row indices one word must produce, in ascending order.
  function automatic void predict_selected_rows(
      input logic [bsbie_pkg::WordBits-1:0]     mask,
      input logic [bsbie_pkg::WordIdxWidth-1:0] widx);
    int unsigned                    rows;
    int unsigned                    rem;
    int unsigned                    b;
    logic [bsbie_pkg::WordBits-1:0] bits;
    rows = (row_count_q > bsbie_pkg::BatchRows) ? bsbie_pkg::BatchRows : row_count_q;
    rem  = rows % bsbie_pkg::WordBits;
    bits = mask;
    if (widx >= live_word_count()) return;
    // The last used word keeps only the bits below the row count.
    if (rem != 0 && widx == live_word_count() - 1) bits &= (64'd1 << rem) - 64'd1;
    for (b = 0; b < bsbie_pkg::WordBits; b++) begin
      if (bits[b]) begin
        expect_row(bsbie_pkg::RowIdxWidth'(widx * bsbie_pkg::WordBits + b),
                   ((bits >> (b + 1)) == '0));
      end
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Presents one word, with random idle cycles ahead of it, and returns at
  // the edge where the unit takes it.
  task automatic send_word(input logic [bsbie_pkg::WordBits-1:0] mask,
                           input logic [bsbie_pkg::WordIdxWidth-1:0] widx);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= bsbie_pkg::InDataWidth'({widx, mask});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Stops sending, waits for every predicted row, then lets the scanner
  // finish any word that produces no rows.
  task automatic wait_for_drain(input int unsigned settle);
    s_axis_tvalid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Only called while the unit is idle.
  task automatic write_row_count(input logic [bsbie_pkg::RowCountWidth-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    row_count_q  = value;
  endtask

  function automatic logic [bsbie_pkg::RowCountWidth-1:0] pick_row_count();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return bsbie_pkg::RowCountWidth'(bsbie_pkg::BatchRows);
      3:       return bsbie_pkg::RowCountWidth'($urandom_range(63, 1));
      4:       return bsbie_pkg::RowCountWidth'(bsbie_pkg::WordBits * $urandom_range(32, 1));
      default: return bsbie_pkg::RowCountWidth'($urandom_range(4095));
    endcase
  endfunction

  // Mixes empty, full, sparse, low-heavy and fully random words.
  function automatic logic [bsbie_pkg::WordBits-1:0] random_mask();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(63);
      3:       return (64'd1 << $urandom_range(63)) | (64'd1 << $urandom_range(63))
                      | (64'd1 << $urandom_range(63));
      4:       return {$urandom, $urandom} >> $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Favors words that are inside the used range, and the trimmed last word
  // in particular, so that most words actually produce rows.
  function automatic logic [bsbie_pkg::WordIdxWidth-1:0] random_word_index();
    int unsigned r;
    r = $urandom_range(99);
    if (live_word_count() == 0 || r < 20)
      return bsbie_pkg::WordIdxWidth'($urandom_range(31));
    if (r < 40) return bsbie_pkg::WordIdxWidth'(live_word_count() - 1);
    return bsbie_pkg::WordIdxWidth'($urandom_range(live_word_count() - 1, 0));
  endfunction

  // The receiver stalls at random; the percentage changes between phases.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Output checker: every row transaction is matched against the oldest
  // prediction, field by field, including the zero padding of tdata.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_rows.size() == 0) begin
        report_mismatch($sformatf("unexpected row transaction, row_index %0d last %0b",
                                  m_axis_tdata[bsbie_pkg::RowIdxWidth-1:0],
                                  m_axis_tlast));
      end else begin
        if (m_axis_tdata[bsbie_pkg::RowIdxWidth-1:0] != pending_rows[0].row)
          report_mismatch($sformatf("row_index expected %0d, got %0d",
                                    pending_rows[0].row,
                                    m_axis_tdata[bsbie_pkg::RowIdxWidth-1:0]));
        if (m_axis_tlast != pending_rows[0].last)
          report_mismatch($sformatf("last_of_word for row %0d expected %0b, got %0b",
                                    pending_rows[0].row, pending_rows[0].last,
                                    m_axis_tlast));
        if (m_axis_tdata[bsbie_pkg::OutDataWidth-1:bsbie_pkg::RowIdxWidth] != '0)
          report_mismatch($sformatf("tdata padding expected 0, got %0h",
                            m_axis_tdata[bsbie_pkg::OutDataWidth-1:bsbie_pkg::RowIdxWidth]));
        void'(pending_rows.pop_front());
      end
    end
  end

  // Watchdog: counts cycles in which neither stream moves a transaction.
  initial begin
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("bitmap_set_bit_index_extract_unit verification failed");
    $finish;
  end

  initial begin
    int unsigned                        tx_pct [3];
    int unsigned                        rx_pct [3];
    int unsigned                        i;
    int unsigned                        phase;
    int unsigned                        seg;
    int unsigned                        k;
    logic [bsbie_pkg::WordBits-1:0]     mask;
    logic [bsbie_pkg::WordIdxWidth-1:0] widx;
    tx_pct = '{11, 69, 0};
    rx_pct = '{69, 11, 0};
    tx_idle_pct = tx_pct[0];
    rx_idle_pct = rx_pct[0];

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. A change of row count is written only once the unit
    // has gone quiet.
    for (i = 0; i < $size(Plan); i++) begin
      if (Plan[i].rc != row_count_q) begin
        wait_for_drain(SettleCycles);
        write_row_count(Plan[i].rc);
      end
      send_word(Plan[i].mask, Plan[i].widx);
      if (Plan[i].typed) begin
        if (Plan[i].hit) expect_row(Plan[i].idx, 1'b1);
      end else begin
        predict_selected_rows(Plan[i].mask, Plan[i].widx);
      end
    end

    // Random words: three idle patterns, several row counts in each.
    for (phase = 0; phase < 3; phase++) begin
      tx_idle_pct = tx_pct[phase];
      rx_idle_pct = rx_pct[phase];
      for (seg = 0; seg < 4; seg++) begin
        wait_for_drain(SettleCycles);
        write_row_count(pick_row_count());
        for (k = 0; k < 32; k++) begin
          // Now and then the sender holds off until the output has caught up.
          if ($urandom_range(99) < 3) wait_for_drain(0);
          mask = random_mask();
          widx = random_word_index();
          send_word(mask, widx);
          predict_selected_rows(mask, widx);
        end
      end
    end

    wait_for_drain(100);
    if (mismatch_count == 0)
      $display("bitmap_set_bit_index_extract_unit verification clean");
    else
      $display("bitmap_set_bit_index_extract_unit verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
src/bsbie_pkg.sv
src/bsbie_scan.sv
src/bsbie_out.sv
src/bitmap_set_bit_index_extract_unit.sv
verif/tb.sv
